// ===== rtl/lss_pkg.sv =====
package lss_pkg;

    // Window depth and line counter width.
    localparam int LOOK_BYTES = 5;
    localparam int LINE_BITS  = 16;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_ELL0  = 8'hE2;
    localparam logic [7:0] CH_ELL1  = 8'h80;
    localparam logic [7:0] CH_ELL2  = 8'hA6;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CONT  = 2'd1;
    localparam logic [1:0] ERR_TLDR  = 2'd2;
    localparam logic [1:0] ERR_DELIM = 2'd3;

    // Input item kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]           char_out;
        logic                 lexeme_first;
        logic                 lexeme_final;
        logic [LINE_BITS-1:0] line_number;
        logic [1:0]           err_code;
        logic                 end_of_file;
        logic                 run_last;
    } result_t;

    // What the scan engine hands to the output stage in one cycle.
    typedef struct packed {
        logic    r_valid;
        result_t r;
        logic    step_end;
    } emit_t;

    typedef enum logic [3:0] {
        M_IDLE,
        M_TOKEN,
        M_STRING,
        M_BTW,
        M_COMMENT,
        M_AFTER,
        M_CONT,
        M_ZTAIL
    } mode_e;

    typedef enum logic [1:0] {
        P_WAIT,
        P_RUN,
        P_DRAIN
    } phase_e;

    function automatic logic is_nl(input logic [7:0] c);
        return c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT
            || c == CH_FF || c == CH_CR;
    endfunction

    // True when a lexeme ends before the byte b1 (b2, b3 follow it).
    function automatic logic ends_at(input logic [7:0] b1, input logic [7:0] b2,
                                     input logic [7:0] b3);
        return b1 == CH_NUL || is_space(b1) || b1 == CH_COMMA || b1 == CH_BANG
            || b1 == CH_QMARK || (b1 == CH_APOS && b2 == CH_Z)
            || (b1 == CH_DOT && b2 == CH_DOT && b3 == CH_DOT)
            || (b1 == CH_ELL0 && b2 == CH_ELL1 && b3 == CH_ELL2);
    endfunction

    // Length of a line end (CR, LF or CRLF) starting at x.
    function automatic logic [1:0] nl_len(input logic [7:0] x, input logic [7:0] y);
        if (x == CH_CR && y == CH_LF)
        begin
            return 2'd2;
        end
        return is_nl(x) ? 2'd1 : 2'd0;
    endfunction

endpackage

// ===== rtl/lexeme_splitter_byte_stream.sv =====
// Lexeme splitter for a source byte stream.
// The input channel (in_valid, in_ready, in_data) takes one transaction per
// source byte, or an end-of-buffer marker. The output channel (out_valid,
// out_ready, out_data) gives one transaction per lexeme byte, newline lexeme,
// end lexeme or error, each with its line number; run_last marks the final
// result caused by one input transaction.
// A two-entry input queue feeds a scan engine that makes one decision per
// cycle, while it runs and the output stage does not hold it, over a
// five-byte lookahead window. Output lags the input by four bytes of
// lookahead. The engine appends a byte to the window, then makes the
// decisions it triggers; it takes the next byte from the queue only after
// those decisions are done. An end-of-buffer marker runs decisions on the
// pending bytes and then closes the buffer.
// Results pass through a holding register and an output register.
// Reset clears the queue, scan state and output; no transaction is pending.
// When the receiver stalls, the output register holds and the engine and
// queue fill and then drop in_ready.
module lexeme_splitter_byte_stream (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lss_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lss_pkg::result_t  out_data
);

    logic              q_valid;
    logic              q_pop;
    lss_pkg::in_item_t q_data;
    logic              adv;
    lss_pkg::emit_t    emit;

    // Front: input queue.
    lss_in_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    // Back: scan engine.
    lss_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .adv     (adv),
        .emit    (emit)
    );

    // Result holding and output register.
    lss_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .adv       (adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/lss_in_queue.sv =====
module lss_in_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lss_pkg::in_item_t  in_data,
    output logic               q_valid,
    input  logic               q_pop,
    output lss_pkg::in_item_t  q_data
);

    // Two-entry queue between the input channel and the scan engine.
    lss_pkg::in_item_t slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        fill_reg;
    logic              push;
    logic              pop;

    assign in_ready = fill_reg != 2'd2;
    assign q_valid  = fill_reg != 2'd0;
    assign q_data   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/lss_engine.sv =====
module lss_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  lss_pkg::in_item_t  q_data,
    input  logic               adv,
    output lss_pkg::emit_t     emit
);

    lss_pkg::phase_e                 phase_reg, phase_next;
    lss_pkg::mode_e                  mode_reg, mode_next;
    logic [7:0]                      win_reg [lss_pkg::LOOK_BYTES];
    logic [7:0]                      win_next [lss_pkg::LOOK_BYTES];
    logic [2:0]                      count_reg, count_next;
    logic [lss_pkg::LINE_BITS-1:0]   line_reg, line_next;
    logic                            als_reg, als_next;
    logic [15:0]                     prior_reg, prior_next;
    logic                            halt_reg, halt_next;

    // Decision of one scan step over the window.
    logic [7:0]                      a [lss_pkg::LOOK_BYTES];
    logic [2:0]                      k;
    logic                            bump;
    logic                            fin;
    logic                            lead;
    logic                            esc;
    logic [1:0]                      n0;
    logic [1:0]                      n3;
    logic [2:0]                      kk;
    logic [7:0]                      rc;
    logic                            rfirst;
    logic                            rfinal;
    logic [1:0]                      rerr;
    logic                            reof;
    logic                            rv;
    logic                            do_decide;
    logic [2:0]                      cnt_after;
    logic                            append;
    logic                            step_end;

    // Bytes past the fill level read as zero.
    always_comb
    begin
        for (int i = 0; i < lss_pkg::LOOK_BYTES; i++)
        begin
            a[i] = (3'(i) < count_reg) ? win_reg[i] : lss_pkg::CH_NUL;
        end
    end

    // One decision: mode update, results and bytes consumed.
    always_comb
    begin
        mode_next  = mode_reg;
        als_next   = als_reg;
        prior_next = prior_reg;
        halt_next  = halt_reg;
        k      = 3'd0;
        bump   = 1'b0;
        lead   = 1'b0;
        rv     = 1'b0;
        rc     = a[0];
        rfirst = 1'b0;
        rfinal = 1'b0;
        rerr   = lss_pkg::ERR_NONE;
        reof   = 1'b0;
        fin    = lss_pkg::ends_at(a[1], a[2], a[3]);
        esc    = prior_reg[7:0] == lss_pkg::CH_COLON && prior_reg[15:8] != lss_pkg::CH_COLON;
        n0     = lss_pkg::nl_len(a[0], a[1]);
        n3     = lss_pkg::nl_len(a[3], a[4]);

        unique case (mode_reg)
            lss_pkg::M_TOKEN:
            begin
                rv     = 1'b1;
                rfinal = fin;
                if (fin)
                begin
                    mode_next = lss_pkg::M_IDLE;
                end
                k = 3'd1;
            end
            lss_pkg::M_STRING:
            begin
                if (a[0] == lss_pkg::CH_QUOTE && !esc)
                begin
                    if (!fin)
                    begin
                        rv        = 1'b1;
                        rc        = lss_pkg::CH_NUL;
                        rerr      = lss_pkg::ERR_DELIM;
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        rv        = 1'b1;
                        rfinal    = 1'b1;
                        mode_next = lss_pkg::M_IDLE;
                        k         = 3'd1;
                    end
                end
                else
                begin
                    prior_next = {prior_reg[7:0], a[0]};
                    rv         = 1'b1;
                    rfinal     = a[1] == lss_pkg::CH_NUL || lss_pkg::is_nl(a[1]);
                    if (rfinal)
                    begin
                        mode_next = lss_pkg::M_IDLE;
                    end
                    k = 3'd1;
                end
            end
            lss_pkg::M_BTW:
            begin
                if (a[0] == lss_pkg::CH_NUL)
                begin
                    rv = 1'b1; rc = lss_pkg::CH_DOLL; rfirst = 1'b1; rfinal = 1'b1;
                    reof = 1'b1; halt_next = 1'b1;
                end
                else if (lss_pkg::is_nl(a[0]))
                begin
                    mode_next = lss_pkg::M_IDLE;
                end
                else
                begin
                    k = 3'd1;
                end
            end
            lss_pkg::M_COMMENT:
            begin
                if (a[0] == lss_pkg::CH_NUL)
                begin
                    rv = 1'b1; rc = lss_pkg::CH_DOLL; rfirst = 1'b1; rfinal = 1'b1;
                    reof = 1'b1; halt_next = 1'b1;
                end
                else if (a[0] == lss_pkg::CH_T && a[1] == lss_pkg::CH_L
                         && a[2] == lss_pkg::CH_D && a[3] == lss_pkg::CH_R)
                begin
                    k         = 3'd4;
                    mode_next = lss_pkg::M_AFTER;
                end
                else if (n0 != 2'd0)
                begin
                    bump = 1'b1;
                    k    = {1'b0, n0};
                end
                else
                begin
                    k = 3'd1;
                end
            end
            lss_pkg::M_AFTER:
            begin
                if (lss_pkg::is_space(a[0]) && !lss_pkg::is_nl(a[0]))
                begin
                    k = 3'd1;
                end
                else if (a[0] == lss_pkg::CH_COMMA || lss_pkg::is_nl(a[0]))
                begin
                    mode_next = lss_pkg::M_IDLE;
                end
                else
                begin
                    rv = 1'b1; rc = lss_pkg::CH_NUL; rerr = lss_pkg::ERR_TLDR;
                    halt_next = 1'b1;
                end
            end
            lss_pkg::M_CONT:
            begin
                if (lss_pkg::is_nl(a[0]))
                begin
                    rv = 1'b1; rc = lss_pkg::CH_NUL; rerr = lss_pkg::ERR_CONT;
                    halt_next = 1'b1;
                end
                else if (lss_pkg::is_space(a[0]))
                begin
                    k = 3'd1;
                end
                else
                begin
                    mode_next = lss_pkg::M_IDLE;
                    lead      = 1'b1;
                end
            end
            lss_pkg::M_ZTAIL:
            begin
                rv        = 1'b1;
                rc        = lss_pkg::CH_Z;
                rfinal    = 1'b1;
                k         = 3'd2;
                mode_next = lss_pkg::M_IDLE;
            end
            default:
            begin
                mode_next = lss_pkg::M_IDLE;
                lead      = 1'b1;
            end
        endcase

        // Start of a new lexeme.
        if (lead)
        begin
            priority if (a[0] == lss_pkg::CH_NUL)
            begin
                rv = 1'b1; rc = lss_pkg::CH_DOLL; rfirst = 1'b1; rfinal = 1'b1;
                reof = 1'b1; halt_next = 1'b1;
            end
            else if (a[0] == lss_pkg::CH_COMMA)
            begin
                rv = 1'b1; rc = lss_pkg::CH_LF; rfirst = 1'b1; rfinal = 1'b1;
                als_next = 1'b1; k = 3'd1;
            end
            else if (a[0] == lss_pkg::CH_BANG || a[0] == lss_pkg::CH_QMARK)
            begin
                rv = 1'b1; rfirst = 1'b1; rfinal = 1'b1;
                als_next = 1'b0; k = 3'd1;
            end
            else if (a[0] == lss_pkg::CH_APOS && a[1] == lss_pkg::CH_Z)
            begin
                rv = 1'b1; rfirst = 1'b1;
                als_next  = 1'b0;
                mode_next = lss_pkg::M_ZTAIL;
            end
            else if (n0 != 2'd0)
            begin
                rv = 1'b1; rc = lss_pkg::CH_LF; rfirst = 1'b1; rfinal = 1'b1;
                bump = 1'b1; als_next = 1'b1; k = {1'b0, n0};
            end
            else if (lss_pkg::is_space(a[0]))
            begin
                k = 3'd1;
            end
            else if (n3 != 2'd0 && ((a[0] == lss_pkg::CH_DOT && a[1] == lss_pkg::CH_DOT
                     && a[2] == lss_pkg::CH_DOT) || (a[0] == lss_pkg::CH_ELL0
                     && a[1] == lss_pkg::CH_ELL1 && a[2] == lss_pkg::CH_ELL2)))
            begin
                k         = 3'd3 + {1'b0, n3};
                bump      = 1'b1;
                mode_next = lss_pkg::M_CONT;
            end
            else if (als_reg && a[0] == lss_pkg::CH_O && a[1] == lss_pkg::CH_B
                     && a[2] == lss_pkg::CH_T && a[3] == lss_pkg::CH_W)
            begin
                k         = 3'd4;
                mode_next = lss_pkg::M_COMMENT;
            end
            else if (a[0] == lss_pkg::CH_B && a[1] == lss_pkg::CH_T
                     && a[2] == lss_pkg::CH_W)
            begin
                k         = 3'd3;
                mode_next = lss_pkg::M_BTW;
            end
            else if (a[0] == lss_pkg::CH_QUOTE)
            begin
                als_next   = 1'b0;
                prior_next = {8'h00, lss_pkg::CH_QUOTE};
                rv         = 1'b1;
                rfirst     = 1'b1;
                rfinal     = a[1] == lss_pkg::CH_NUL || lss_pkg::is_nl(a[1]);
                mode_next  = rfinal ? lss_pkg::M_IDLE : lss_pkg::M_STRING;
                k          = 3'd1;
            end
            else
            begin
                als_next  = 1'b0;
                rv        = 1'b1;
                rfirst    = 1'b1;
                rfinal    = fin;
                mode_next = fin ? lss_pkg::M_IDLE : lss_pkg::M_TOKEN;
                k         = 3'd1;
            end
        end
    end

    // Sequencing of a transaction: append, decide loop, end-of-buffer drain.
    always_comb
    begin
        phase_next = phase_reg;
        q_pop      = 1'b0;
        do_decide  = 1'b0;
        append     = 1'b0;
        step_end   = 1'b0;
        emit       = '0;
        kk         = (k > count_reg) ? count_reg : k;
        cnt_after  = count_reg - kk;
        line_next  = line_reg;
        count_next = count_reg;
        for (int i = 0; i < lss_pkg::LOOK_BYTES; i++)
        begin
            win_next[i] = win_reg[i];
        end

        unique case (phase_reg)
            lss_pkg::P_WAIT:
            begin
                if (q_valid)
                begin
                    // The queue entry is only taken when the engine advances.
                    q_pop = adv;
                    if (q_data.kind == lss_pkg::KIND_END)
                    begin
                        phase_next = lss_pkg::P_DRAIN;
                    end
                    else if (halt_reg)
                    begin
                        step_end = 1'b1;
                    end
                    else
                    begin
                        append = 1'b1;
                        if (count_reg == 3'(lss_pkg::LOOK_BYTES - 1))
                        begin
                            phase_next = lss_pkg::P_RUN;
                        end
                        else
                        begin
                            step_end = 1'b1;
                        end
                    end
                end
            end
            lss_pkg::P_RUN:
            begin
                do_decide = 1'b1;
                if (halt_next || cnt_after < 3'(lss_pkg::LOOK_BYTES))
                begin
                    step_end   = 1'b1;
                    phase_next = lss_pkg::P_WAIT;
                end
            end
            default:
            begin
                if (halt_reg || count_reg == 3'd0)
                begin
                    step_end   = 1'b1;
                    phase_next = lss_pkg::P_WAIT;
                    if (!halt_reg)
                    begin
                        emit.r_valid        = 1'b1;
                        emit.r.line_number  = line_reg;
                        if (mode_reg == lss_pkg::M_AFTER)
                        begin
                            emit.r.err_code = lss_pkg::ERR_TLDR;
                        end
                        else
                        begin
                            emit.r.char_out     = lss_pkg::CH_DOLL;
                            emit.r.lexeme_first = 1'b1;
                            emit.r.lexeme_final = 1'b1;
                            emit.r.end_of_file  = 1'b1;
                        end
                    end
                end
                else
                begin
                    do_decide = 1'b1;
                end
            end
        endcase

        if (append)
        begin
            for (int i = 0; i < lss_pkg::LOOK_BYTES; i++)
            begin
                if (3'(i) == count_reg)
                begin
                    win_next[i] = q_data.char_in;
                end
            end
            count_next = count_reg + 3'd1;
        end

        if (do_decide)
        begin
            emit.r_valid        = rv;
            emit.r.char_out     = rc;
            emit.r.lexeme_first = rfirst;
            emit.r.lexeme_final = rfinal;
            emit.r.line_number  = line_reg;
            emit.r.err_code     = rerr;
            emit.r.end_of_file  = reof;
            if (bump && line_reg != lss_pkg::LINE_MAX)
            begin
                line_next = line_reg + lss_pkg::LINE_ONE;
            end
            count_next = cnt_after;
            for (int j = 1; j <= lss_pkg::LOOK_BYTES; j++)
            begin
                if (3'(j) == kk)
                begin
                    for (int i = 0; i + j < lss_pkg::LOOK_BYTES; i++)
                    begin
                        win_next[i] = win_reg[i + j];
                    end
                end
            end
        end
        emit.step_end = step_end;
    end

    // Window bytes carry no reset.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < lss_pkg::LOOK_BYTES; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Scan state; the end of a buffer returns everything to reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lss_pkg::P_WAIT;
            mode_reg  <= lss_pkg::M_IDLE;
            count_reg <= 3'd0;
            line_reg  <= lss_pkg::LINE_ONE;
            als_reg   <= 1'b1;
            prior_reg <= 16'h0000;
            halt_reg  <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            if (phase_reg == lss_pkg::P_DRAIN && step_end)
            begin
                mode_reg  <= lss_pkg::M_IDLE;
                count_reg <= 3'd0;
                line_reg  <= lss_pkg::LINE_ONE;
                als_reg   <= 1'b1;
                prior_reg <= 16'h0000;
                halt_reg  <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                line_reg  <= line_next;
                if (do_decide)
                begin
                    mode_reg  <= mode_next;
                    als_reg   <= als_next;
                    prior_reg <= prior_next;
                    halt_reg  <= halt_next;
                end
            end
        end
    end

endmodule

// ===== rtl/lss_out_stage.sv =====
module lss_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  lss_pkg::emit_t    emit,
    output logic              adv,
    output logic              out_valid,
    input  logic              out_ready,
    output lss_pkg::result_t  out_data
);

    // One result is held back until it is known whether it ends its transaction.
    lss_pkg::result_t pend_reg;
    logic             pend_valid_reg;
    logic             pend_done_reg;
    logic             step_emit_reg;
    lss_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             can_push;
    logic             mark;
    logic             push;
    lss_pkg::result_t push_data;
    lss_pkg::result_t new_data;

    assign can_push  = !out_valid_reg || out_ready;
    assign adv       = !pend_valid_reg || can_push;
    assign mark      = emit.step_end && !emit.r_valid && step_emit_reg && pend_valid_reg;
    assign push      = adv && pend_valid_reg && (emit.r_valid || pend_done_reg || mark);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        push_data          = pend_reg;
        push_data.run_last = pend_reg.run_last | mark;
        new_data           = emit.r;
        new_data.run_last  = emit.step_end;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= push_data;
        end
        if (adv && emit.r_valid)
        begin
            pend_reg <= new_data;
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_done_reg  <= 1'b0;
            step_emit_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                if (emit.r_valid)
                begin
                    pend_valid_reg <= 1'b1;
                    pend_done_reg  <= emit.step_end;
                end
                else if (push)
                begin
                    pend_valid_reg <= 1'b0;
                    pend_done_reg  <= 1'b0;
                end
                step_emit_reg <= emit.step_end ? 1'b0 : (step_emit_reg | emit.r_valid);
            end
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 340;
    localparam int MAX_PER_ITEM = 8;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    lss_pkg::in_item_t in_data;
    logic              out_valid;
    logic              out_ready;
    lss_pkg::result_t  out_data;

    lexeme_splitter_byte_stream i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Directed stimulus row; chk rows carry a typed value for the last result.
    typedef struct {
        lss_pkg::in_item_t item;
        bit                chk;
        logic [7:0]        ch;
        logic [1:0]        err;
    } row_t;

    lss_pkg::result_t lexeme_queue[$];
    lss_pkg::result_t step_res[$];
    row_t             rows[$];
    logic [7:0]       frag[$];
    int               errors;
    int               cycles;
    bit               quiet;

    // Scanner state of the predictor.
    logic [7:0]     win[lss_pkg::LOOK_BYTES];
    int             wcnt;
    lss_pkg::mode_e mode;
    logic [15:0]    lnum;
    bit             sol;
    logic [15:0]    prev2;
    bit             halt;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[lexeme_splitter_byte_stream] ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] peek(int i);
        return (i < wcnt && i < lss_pkg::LOOK_BYTES) ? win[i] : lss_pkg::CH_NUL;
    endfunction

    function automatic bit seq3(int i, logic [7:0] a, logic [7:0] b, logic [7:0] c);
        return peek(i) == a && peek(i + 1) == b && peek(i + 2) == c;
    endfunction

    function automatic bit eol(logic [7:0] c);
        return c == lss_pkg::CH_CR || c == lss_pkg::CH_LF;
    endfunction

    function automatic bit blank(logic [7:0] c);
        return c == lss_pkg::CH_SP || c == lss_pkg::CH_TAB || c == lss_pkg::CH_LF
            || c == lss_pkg::CH_VT || c == lss_pkg::CH_FF || c == lss_pkg::CH_CR;
    endfunction

    // A lexeme stops in front of position i.
    function automatic bit lex_stop(int i);
        logic [7:0] c;
        c = peek(i);
        return c == lss_pkg::CH_NUL || blank(c) || c == lss_pkg::CH_COMMA
            || c == lss_pkg::CH_BANG || c == lss_pkg::CH_QMARK
            || (c == lss_pkg::CH_APOS && peek(i + 1) == lss_pkg::CH_Z)
            || seq3(i, lss_pkg::CH_DOT, lss_pkg::CH_DOT, lss_pkg::CH_DOT)
            || seq3(i, lss_pkg::CH_ELL0, lss_pkg::CH_ELL1, lss_pkg::CH_ELL2);
    endfunction

    function automatic int eol_len(int i);
        if (peek(i) == lss_pkg::CH_CR && peek(i + 1) == lss_pkg::CH_LF)
        begin
            return 2;
        end
        return eol(peek(i)) ? 1 : 0;
    endfunction

    task automatic drop(int k);
        if (k > wcnt)
        begin
            k = wcnt;
        end
        for (int j = 0; j + k < wcnt; j++)
        begin
            win[j] = win[j + k];
        end
        wcnt -= k;
    endtask

    task automatic put(logic [7:0] c, bit first, bit fin, logic [1:0] err, bit eof);
        lss_pkg::result_t r;
        r.char_out     = c;
        r.lexeme_first = first;
        r.lexeme_final = fin;
        r.line_number  = lnum;
        r.err_code     = err;
        r.end_of_file  = eof;
        r.run_last     = 1'b0;
        if (step_res.size() < MAX_PER_ITEM)
        begin
            step_res.push_back(r);
        end
    endtask

    task automatic bump();
        if (lnum != lss_pkg::LINE_MAX)
        begin
            lnum++;
        end
    endtask

    task automatic end_scan();
        put(lss_pkg::CH_DOLL, 1, 1, lss_pkg::ERR_NONE, 1);
        halt = 1;
    endtask

    task automatic abort(logic [1:0] code);
        put(lss_pkg::CH_NUL, 0, 0, code, 0);
        halt = 1;
    endtask

    task automatic clear_scan();
        wcnt  = 0;
        mode  = lss_pkg::M_IDLE;
        lnum  = lss_pkg::LINE_ONE;
        sol   = 1;
        prev2 = '0;
        halt  = 0;
    endtask

    // One decision of the scanner over the lookahead window.
    task automatic scan_one();
        logic [7:0] c;
        int         n;
        bit         fin;
        c = peek(0);
        case (mode)
            lss_pkg::M_TOKEN:
            begin
                fin = lex_stop(1);
                put(c, 0, fin, lss_pkg::ERR_NONE, 0);
                if (fin)
                begin
                    mode = lss_pkg::M_IDLE;
                end
                drop(1);
                return;
            end
            lss_pkg::M_STRING:
            begin
                if (c == lss_pkg::CH_QUOTE && !(prev2[7:0] == lss_pkg::CH_COLON
                    && prev2[15:8] != lss_pkg::CH_COLON))
                begin
                    if (!lex_stop(1))
                    begin
                        abort(lss_pkg::ERR_DELIM);
                        return;
                    end
                    put(c, 0, 1, lss_pkg::ERR_NONE, 0);
                    mode = lss_pkg::M_IDLE;
                    drop(1);
                    return;
                end
                prev2 = {prev2[7:0], c};
                fin = peek(1) == lss_pkg::CH_NUL || eol(peek(1));
                put(c, 0, fin, lss_pkg::ERR_NONE, 0);
                if (fin)
                begin
                    mode = lss_pkg::M_IDLE;
                end
                drop(1);
                return;
            end
            lss_pkg::M_BTW:
            begin
                if (c == lss_pkg::CH_NUL)
                begin
                    end_scan();
                end
                else if (eol(c))
                begin
                    mode = lss_pkg::M_IDLE;
                end
                else
                begin
                    drop(1);
                end
                return;
            end
            lss_pkg::M_COMMENT:
            begin
                if (c == lss_pkg::CH_NUL)
                begin
                    end_scan();
                    return;
                end
                if (seq3(0, lss_pkg::CH_T, lss_pkg::CH_L, lss_pkg::CH_D)
                    && peek(3) == lss_pkg::CH_R)
                begin
                    drop(4);
                    mode = lss_pkg::M_AFTER;
                    return;
                end
                n = eol_len(0);
                if (n != 0)
                begin
                    bump();
                    drop(n);
                end
                else
                begin
                    drop(1);
                end
                return;
            end
            lss_pkg::M_AFTER:
            begin
                if (blank(c) && !eol(c))
                begin
                    drop(1);
                end
                else if (c == lss_pkg::CH_COMMA || eol(c))
                begin
                    mode = lss_pkg::M_IDLE;
                end
                else
                begin
                    abort(lss_pkg::ERR_TLDR);
                end
                return;
            end
            lss_pkg::M_CONT:
            begin
                if (eol(c))
                begin
                    abort(lss_pkg::ERR_CONT);
                    return;
                end
                if (blank(c))
                begin
                    drop(1);
                    return;
                end
                mode = lss_pkg::M_IDLE;
            end
            default:
            begin
                mode = lss_pkg::M_IDLE;
            end
        endcase

        // Start of a new lexeme.
        if (c == lss_pkg::CH_NUL)
        begin
            end_scan();
            return;
        end
        if (c == lss_pkg::CH_COMMA)
        begin
            put(lss_pkg::CH_LF, 1, 1, lss_pkg::ERR_NONE, 0);
            sol = 1;
            drop(1);
            return;
        end
        if (c == lss_pkg::CH_BANG || c == lss_pkg::CH_QMARK)
        begin
            put(c, 1, 1, lss_pkg::ERR_NONE, 0);
            sol = 0;
            drop(1);
            return;
        end
        if (c == lss_pkg::CH_APOS && peek(1) == lss_pkg::CH_Z)
        begin
            put(lss_pkg::CH_APOS, 1, 0, lss_pkg::ERR_NONE, 0);
            put(lss_pkg::CH_Z, 0, 1, lss_pkg::ERR_NONE, 0);
            sol = 0;
            drop(2);
            return;
        end
        n = eol_len(0);
        if (n != 0)
        begin
            put(lss_pkg::CH_LF, 1, 1, lss_pkg::ERR_NONE, 0);
            bump();
            sol = 1;
            drop(n);
            return;
        end
        if (blank(c))
        begin
            drop(1);
            return;
        end
        if (seq3(0, lss_pkg::CH_ELL0, lss_pkg::CH_ELL1, lss_pkg::CH_ELL2)
            || seq3(0, lss_pkg::CH_DOT, lss_pkg::CH_DOT, lss_pkg::CH_DOT))
        begin
            n = eol_len(3);
            if (n != 0)
            begin
                drop(3 + n);
                bump();
                mode = lss_pkg::M_CONT;
                return;
            end
        end
        if (sol && c == lss_pkg::CH_O
            && seq3(1, lss_pkg::CH_B, lss_pkg::CH_T, lss_pkg::CH_W))
        begin
            drop(4);
            mode = lss_pkg::M_COMMENT;
            return;
        end
        if (seq3(0, lss_pkg::CH_B, lss_pkg::CH_T, lss_pkg::CH_W))
        begin
            drop(3);
            mode = lss_pkg::M_BTW;
            return;
        end
        sol = 0;
        if (c == lss_pkg::CH_QUOTE)
        begin
            prev2 = {8'h00, lss_pkg::CH_QUOTE};
            fin = peek(1) == lss_pkg::CH_NUL || eol(peek(1));
            put(c, 1, fin, lss_pkg::ERR_NONE, 0);
            mode = fin ? lss_pkg::M_IDLE : lss_pkg::M_STRING;
            drop(1);
            return;
        end
        fin = lex_stop(1);
        put(c, 1, fin, lss_pkg::ERR_NONE, 0);
        mode = fin ? lss_pkg::M_IDLE : lss_pkg::M_TOKEN;
        drop(1);
    endtask

    // Works out the results of one accepted transaction into step_res.
    task automatic predict_lexemes(lss_pkg::in_item_t item);
        step_res.delete();
        if (item.kind == lss_pkg::KIND_DATA)
        begin
            if (!halt)
            begin
                if (wcnt < lss_pkg::LOOK_BYTES)
                begin
                    win[wcnt] = item.char_in;
                    wcnt++;
                end
                while (!halt && wcnt >= lss_pkg::LOOK_BYTES)
                begin
                    scan_one();
                end
            end
        end
        else
        begin
            if (!halt)
            begin
                while (!halt && wcnt > 0)
                begin
                    scan_one();
                end
                if (!halt)
                begin
                    if (mode == lss_pkg::M_AFTER)
                    begin
                        abort(lss_pkg::ERR_TLDR);
                    end
                    else
                    begin
                        end_scan();
                    end
                end
            end
            clear_scan();
        end
        if (step_res.size() > 0)
        begin
            step_res[step_res.size() - 1].run_last = 1'b1;
        end
        foreach (step_res[k])
        begin
            lexeme_queue.push_back(step_res[k]);
        end
    endtask

    // Drives one transaction and waits for it to be taken.
    task automatic send(lss_pkg::in_item_t item);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_lexemes(item);
    endtask

    task automatic send_byte(logic [7:0] b);
        lss_pkg::in_item_t it;
        it.kind    = lss_pkg::KIND_DATA;
        it.char_in = b;
        send(it);
    endtask

    task automatic send_end();
        lss_pkg::in_item_t it;
        it.kind    = lss_pkg::KIND_END;
        it.char_in = 8'($urandom);
        send(it);
    endtask

    task automatic add_row(bit is_end, logic [7:0] b, bit chk, logic [7:0] ch, logic [1:0] err);
        row_t r;
        r.item.kind    = is_end ? lss_pkg::KIND_END : lss_pkg::KIND_DATA;
        r.item.char_in = b;
        r.chk          = chk;
        r.ch           = ch;
        r.err          = err;
        rows.push_back(r);
    endtask

    task automatic add_text(string s);
        for (int k = 0; k < s.len(); k++)
        begin
            add_row(0, s[k], 0, 8'h00, lss_pkg::ERR_NONE);
        end
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(8'h80, 8'hFF));
            1: return 8'($urandom_range(8'h30, 8'h39));
            2: return lss_pkg::CH_COLON;
            default: return 8'($urandom_range(8'h41, 8'h5A));
        endcase
    endfunction

    function automatic void add_eol();
        case ($urandom_range(0, 2))
            0: frag.push_back(lss_pkg::CH_LF);
            1: frag.push_back(lss_pkg::CH_CR);
            default:
            begin
                frag.push_back(lss_pkg::CH_CR);
                frag.push_back(lss_pkg::CH_LF);
            end
        endcase
    endfunction

    // Builds one well-formed source fragment, or some noise.
    function automatic void make_fragment();
        frag.delete();
        case ($urandom_range(0, 13))
            0, 1, 2:
            begin
                repeat ($urandom_range(1, 6)) frag.push_back(word_char());
                frag.push_back($urandom_range(0, 3) == 0 ? lss_pkg::CH_TAB : lss_pkg::CH_SP);
            end
            3: add_eol();
            4:
            begin
                case ($urandom_range(0, 3))
                    0: frag.push_back(lss_pkg::CH_COMMA);
                    1: frag.push_back(lss_pkg::CH_BANG);
                    2: frag.push_back(lss_pkg::CH_QMARK);
                    default:
                    begin
                        frag.push_back(lss_pkg::CH_APOS);
                        frag.push_back(lss_pkg::CH_Z);
                    end
                endcase
            end
            5, 6:
            begin
                frag.push_back(lss_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 5))
                begin
                    case ($urandom_range(0, 5))
                        0: frag.push_back(lss_pkg::CH_COLON);
                        1: frag.push_back(lss_pkg::CH_QUOTE);
                        2: frag.push_back(lss_pkg::CH_SP);
                        default: frag.push_back(word_char());
                    endcase
                end
                frag.push_back(lss_pkg::CH_QUOTE);
                if ($urandom_range(0, 4) != 0)
                begin
                    frag.push_back(lss_pkg::CH_SP);
                end
            end
            7:
            begin
                frag.push_back(lss_pkg::CH_B);
                frag.push_back(lss_pkg::CH_T);
                frag.push_back(lss_pkg::CH_W);
                repeat ($urandom_range(0, 4)) frag.push_back(word_char());
                add_eol();
            end
            8:
            begin
                add_eol();
                frag.push_back(lss_pkg::CH_O);
                frag.push_back(lss_pkg::CH_B);
                frag.push_back(lss_pkg::CH_T);
                frag.push_back(lss_pkg::CH_W);
                repeat ($urandom_range(0, 4)) frag.push_back(word_char());
                if ($urandom_range(0, 1) != 0)
                begin
                    add_eol();
                end
                frag.push_back(lss_pkg::CH_T);
                frag.push_back(lss_pkg::CH_L);
                frag.push_back(lss_pkg::CH_D);
                frag.push_back(lss_pkg::CH_R);
                if ($urandom_range(0, 3) != 0)
                begin
                    frag.push_back(lss_pkg::CH_SP);
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    frag.push_back(word_char());
                end
                else
                begin
                    add_eol();
                end
            end
            9:
            begin
                frag.push_back(word_char());
                if ($urandom_range(0, 1) != 0)
                begin
                    frag.push_back(lss_pkg::CH_ELL0);
                    frag.push_back(lss_pkg::CH_ELL1);
                    frag.push_back(lss_pkg::CH_ELL2);
                end
                else
                begin
                    repeat (3) frag.push_back(lss_pkg::CH_DOT);
                end
                add_eol();
                repeat ($urandom_range(0, 2)) frag.push_back(lss_pkg::CH_SP);
                if ($urandom_range(0, 4) == 0)
                begin
                    add_eol();
                end
                else
                begin
                    frag.push_back(word_char());
                end
            end
            10, 11: repeat ($urandom_range(1, 3)) frag.push_back(8'($urandom));
            default:
            begin
                frag.push_back(word_char());
                frag.push_back(lss_pkg::CH_SP);
            end
        endcase
    endfunction

    // Sink side: random stall bursts until the quiet tail.
    initial
    begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                stall = $urandom_range(1, 3) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each output transaction with the oldest expected lexeme result.
    always @(posedge clk)
    begin
        lss_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lexeme_queue.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result %p", out_data);
                end
            end
            else
            begin
                want = lexeme_queue.pop_front();
                if (out_data.char_out !== want.char_out
                    || out_data.lexeme_first !== want.lexeme_first
                    || out_data.lexeme_final !== want.lexeme_final
                    || out_data.line_number !== want.line_number
                    || out_data.err_code !== want.err_code
                    || out_data.end_of_file !== want.end_of_file
                    || out_data.run_last !== want.run_last)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: expected %p, got %p", want, out_data);
                    end
                end
            end
        end
    end

    initial
    begin
        int sent;
        int wait_cycles;
        bit held;
        errors   = 0;
        cycles   = 0;
        quiet    = 0;
        held     = 0;
        in_valid = 1'b0;
        in_data  = '0;
        rst_n    = 1'b0;
        clear_scan();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: end right after reset, single-byte lexemes, high byte,
        // zero byte, then each of the three errors.
        add_row(1, 8'h00, 1, lss_pkg::CH_DOLL, lss_pkg::ERR_NONE);
        add_row(0, lss_pkg::CH_BANG, 0, 8'h00, lss_pkg::ERR_NONE);
        add_text("?'Z,");
        add_row(0, 8'hFF, 0, 8'h00, lss_pkg::ERR_NONE);
        add_text("\r\n");
        add_row(0, lss_pkg::CH_NUL, 0, 8'h00, lss_pkg::ERR_NONE);
        add_row(1, 8'hFF, 1, lss_pkg::CH_DOLL, lss_pkg::ERR_NONE);
        add_text("\"a\"b");
        add_row(1, 8'h00, 1, lss_pkg::CH_NUL, lss_pkg::ERR_DELIM);
        add_text("OBTW TLDRx");
        add_row(1, 8'h00, 1, lss_pkg::CH_NUL, lss_pkg::ERR_TLDR);
        add_text("...\n \n");
        add_row(1, 8'h00, 1, lss_pkg::CH_NUL, lss_pkg::ERR_CONT);
        foreach (rows[k])
        begin
            send(rows[k].item);
            if (rows[k].chk && (step_res.size() == 0
                || step_res[step_res.size() - 1].char_out != rows[k].ch
                || step_res[step_res.size() - 1].err_code != rows[k].err))
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("directed row %0d: expected char %0d err %0d", k, rows[k].ch,
                             rows[k].err);
                end
            end
        end

        // Random part: fragments of source text, with buffer ends now and then.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            make_fragment();
            foreach (frag[k])
            begin
                send_byte(frag[k]);
                sent++;
            end
            if ($urandom_range(0, 11) == 0)
            begin
                send_end();
                sent++;
            end
            else if ($urandom_range(0, 60) == 0)
            begin
                send_byte(lss_pkg::CH_NUL);
                sent++;
            end
            if (sent > RANDOM_ITEMS - 60)
            begin
                quiet = 1;
            end
            // Hold the sender once until the block has caught up.
            if (!held && sent >= RANDOM_ITEMS / 2)
            begin
                held = 1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (lexeme_queue.size() != 0) @(posedge clk);
            end
        end
        send_end();
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (lexeme_queue.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && lexeme_queue.size() == 0)
        begin
            $display("[lexeme_splitter_byte_stream] OK");
        end
        else
        begin
            $display("[lexeme_splitter_byte_stream] ERROR");
        end
        $finish;
    end

endmodule
